/* rtl/rss_pkg.sv */
// Package with the shared constants, payload types and memory port type of the sorted set.
`timescale 1ns / 1ps

package rss_pkg;

  localparam int CAPACITY   = 1024;
  localparam int VALUE_BITS = 17;
  localparam int ADDR_BITS  = $clog2(CAPACITY);
  localparam int COUNT_BITS = $clog2(CAPACITY + 1);
  localparam int POS_BITS   = 10;
  localparam int RANK_BITS  = 10;
  localparam int STAT_BITS  = 2;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_DELETE = 1'b1;

  localparam logic [STAT_BITS-1:0] STATUS_OK   = 2'd0;
  localparam logic [STAT_BITS-1:0] STATUS_FULL = 2'd1;
  localparam logic [STAT_BITS-1:0] STATUS_DUP  = 2'd2;

  typedef struct packed {
    logic                  command;
    logic [VALUE_BITS-1:0] value;
    logic [POS_BITS-1:0]   position;
  } item_t;

  typedef struct packed {
    logic [RANK_BITS-1:0] rank;
    logic [STAT_BITS-1:0] status;
  } result_t;

  typedef struct packed {
    logic                  we;
    logic [ADDR_BITS-1:0]  waddr;
    logic [VALUE_BITS-1:0] wdata;
    logic                  re;
    logic [ADDR_BITS-1:0]  raddr;
  } mem_req_t;

endpackage

/* rtl/rss_mem.sv */
// Value store of the sorted set: one write port and one registered read port.
`timescale 1ns / 1ps

module rss_mem (
  input  logic                          clk_i,
  input  rss_pkg::mem_req_t             req_i,
  output logic [rss_pkg::VALUE_BITS-1:0] rdata_o
);

  logic [rss_pkg::VALUE_BITS-1:0] mem [rss_pkg::CAPACITY];
  logic [rss_pkg::VALUE_BITS-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/rss_ctrl.sv */
// Sequencer of the sorted set: binary search, duplicate check and shift passes over the store.
`timescale 1ns / 1ps

module rss_ctrl (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  rss_pkg::item_t                 item_i,
  output logic                           result_valid_o,
  output rss_pkg::result_t               result_o,
  output rss_pkg::mem_req_t              mem_req_o,
  input  logic [rss_pkg::VALUE_BITS-1:0] mem_rdata_i
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_COMPARE,
    ST_DUP,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_DEL_RD,
    ST_DEL_WR
  } state_e;

  localparam int CB = rss_pkg::COUNT_BITS;
  localparam int AB = rss_pkg::ADDR_BITS;

  state_e                         state_q;
  logic [CB-1:0]                  count_q;
  logic [CB-1:0]                  lo_q;
  logic [CB-1:0]                  hi_q;
  logic [CB-1:0]                  mid_q;
  logic [CB-1:0]                  idx_q;
  logic [rss_pkg::VALUE_BITS-1:0] value_q;
  logic                           result_valid_q;
  rss_pkg::result_t               result_q;

  logic [CB:0]   mid_sum;
  logic [CB-1:0] mid_d;
  logic [CB-1:0] idx_dec;
  logic [CB-1:0] idx_inc;
  logic          accept;

  assign accept  = start && (state_q == ST_IDLE);
  assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid_d   = mid_sum[CB:1];
  assign idx_dec = idx_q - CB'(1);
  assign idx_inc = idx_q + CB'(1);

  always_comb begin
    mem_req_o = '0;
    unique case (state_q)
      ST_SEARCH: begin
        if (lo_q < hi_q) begin
          mem_req_o.re    = 1'b1;
          mem_req_o.raddr = mid_d[AB-1:0];
        end else begin
          mem_req_o.re    = 1'b1;
          mem_req_o.raddr = lo_q[AB-1:0];
        end
      end
      ST_SHIFT_RD: begin
        if (idx_q > lo_q) begin
          mem_req_o.re    = 1'b1;
          mem_req_o.raddr = idx_dec[AB-1:0];
        end else begin
          mem_req_o.we    = 1'b1;
          mem_req_o.waddr = lo_q[AB-1:0];
          mem_req_o.wdata = value_q;
        end
      end
      ST_SHIFT_WR, ST_DEL_WR: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = idx_q[AB-1:0];
        mem_req_o.wdata = mem_rdata_i;
      end
      ST_DEL_RD: begin
        mem_req_o.re    = 1'b1;
        mem_req_o.raddr = idx_inc[AB-1:0];
      end
      default: begin
        mem_req_o = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      count_q        <= '0;
      result_valid_q <= 1'b0;
      lo_q           <= '0;
      hi_q           <= '0;
      mid_q          <= '0;
      idx_q          <= '0;
      value_q        <= '0;
      result_q       <= '0;
    end else begin
      result_valid_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            value_q <= item_i.value;
            lo_q    <= '0;
            hi_q    <= count_q;
            if (item_i.command == rss_pkg::CMD_INSERT) begin
              state_q <= ST_SEARCH;
            end else if (CB'(item_i.position) < count_q) begin
              idx_q   <= CB'(item_i.position);
              state_q <= ST_DEL_RD;
            end
          end
        end
        ST_SEARCH: begin
          if (lo_q < hi_q) begin
            mid_q   <= mid_d;
            state_q <= ST_COMPARE;
          end else if (count_q >= CB'(rss_pkg::CAPACITY)) begin
            result_q.rank   <= lo_q[rss_pkg::RANK_BITS-1:0];
            result_q.status <= rss_pkg::STATUS_FULL;
            result_valid_q  <= 1'b1;
            state_q         <= ST_IDLE;
          end else if (lo_q < count_q) begin
            state_q <= ST_DUP;
          end else begin
            idx_q   <= count_q;
            state_q <= ST_SHIFT_RD;
          end
        end
        ST_COMPARE: begin
          if (mem_rdata_i > value_q) begin
            lo_q <= mid_q + CB'(1);
          end else begin
            hi_q <= mid_q;
          end
          state_q <= ST_SEARCH;
        end
        ST_DUP: begin
          if (mem_rdata_i == value_q) begin
            result_q.rank   <= lo_q[rss_pkg::RANK_BITS-1:0];
            result_q.status <= rss_pkg::STATUS_DUP;
            result_valid_q  <= 1'b1;
            state_q         <= ST_IDLE;
          end else begin
            idx_q   <= count_q;
            state_q <= ST_SHIFT_RD;
          end
        end
        ST_SHIFT_RD: begin
          if (idx_q > lo_q) begin
            state_q <= ST_SHIFT_WR;
          end else begin
            count_q         <= count_q + CB'(1);
            result_q.rank   <= lo_q[rss_pkg::RANK_BITS-1:0];
            result_q.status <= rss_pkg::STATUS_OK;
            result_valid_q  <= 1'b1;
            state_q         <= ST_IDLE;
          end
        end
        ST_SHIFT_WR: begin
          idx_q   <= idx_dec;
          state_q <= ST_SHIFT_RD;
        end
        ST_DEL_RD: begin
          if (idx_inc < count_q) begin
            state_q <= ST_DEL_WR;
          end else begin
            count_q <= count_q - CB'(1);
            state_q <= ST_IDLE;
          end
        end
        ST_DEL_WR: begin
          idx_q   <= idx_inc;
          state_q <= ST_DEL_RD;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy           = (state_q != ST_IDLE);
  assign result_valid_o = result_valid_q;
  assign result_o       = result_q;

endmodule

/* rtl/ranked_sorted_set_top.sv */
// An insert runs the binary search, a read and a compare per step, then the duplicate check, then
// shifts each entry from the insert position to the end up by one place and writes the value; one item at a time.
// A delete moves each entry after the position down by one place, a read and then a write per entry.
// The sequencer makes one read or one write of the store per cycle.
// Reset clears the entry count and the sequencer registers; the store needs no clearing pass.
// The result strobe lasts one cycle and the receiver cannot stall it.
`timescale 1ns / 1ps

module ranked_sorted_set_top (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  rss_pkg::item_t   item_i,
  output logic             result_valid_o,
  output rss_pkg::result_t result_o
);

  rss_pkg::mem_req_t              mem_req;
  logic [rss_pkg::VALUE_BITS-1:0] mem_rdata;

  rss_mem u_mem (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  rss_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .item_i         (item_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o),
    .mem_req_o      (mem_req),
    .mem_rdata_i    (mem_rdata)
  );

endmodule

/* rtl/rss_checker.sv */
// Port-level checker of the sorted set and its bind to the top level.
`timescale 1ns / 1ps

module rss_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             start,
  input logic             busy,
  input rss_pkg::item_t   item_i,
  input logic             result_valid_o,
  input rss_pkg::result_t result_o
);

  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("Result strobe lasted more than one cycle.");

  a_strobe_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy)
    else $error("Result strobe while busy.");

  a_insert_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && item_i.command == rss_pkg::CMD_INSERT) |=> (busy && !result_valid_o))
    else $error("Insert item did not hold the block busy.");

  a_delete_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && item_i.command == rss_pkg::CMD_DELETE) |=> !result_valid_o)
    else $error("Delete item produced a result.");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (result_o.status == rss_pkg::STATUS_OK ||
                        result_o.status == rss_pkg::STATUS_FULL ||
                        result_o.status == rss_pkg::STATUS_DUP))
    else $error("Result carries an unknown status.");

endmodule

bind ranked_sorted_set_top rss_checker u_rss_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .item_i         (item_i),
  .result_valid_o (result_valid_o),
  .result_o       (result_o)
);
